// File: rtl/ssxcf_pkg.sv
package ssxcf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIXEL_BITS = 8;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = 12;
  localparam int CAP_W    = 10;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int VAL_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // sum of one sobel column: a + 2b + c
  localparam int SUM_W = PIXEL_BITS + 2;
  localparam int EXT_W = ((SUM_W > CAP_W) ? SUM_W : CAP_W) + 3;
  localparam int VALUE_MAX = 8 * ((1 << PIXEL_BITS) - 1);

  localparam int SLOTS = 3;
  localparam int CNT_W = 2;

  localparam logic [CAP_W-1:0]    CAP_RESET    = CAP_W'(31);
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRADIENT_CAP = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [VAL_W-1:0] right_value;
    logic [VAL_W-1:0] left_value;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
  } result_t;

  function automatic logic [SUM_W-1:0] column_sum(input logic [PIXEL_BITS-1:0] top,
                                                  input logic [PIXEL_BITS-1:0] mid,
                                                  input logic [PIXEL_BITS-1:0] bot);
    return SUM_W'(top) + (SUM_W'(mid) << 1) + SUM_W'(bot);
  endfunction

  // zero below -cap, double above cap, offset by cap in between, clamped to VALUE_MAX
  function automatic logic [VAL_W-1:0] map_gradient(input logic [SUM_W-1:0] rsum,
                                                    input logic [SUM_W-1:0] lsum,
                                                    input logic [CAP_W-1:0] cap);
    logic signed [EXT_W-1:0] g;
    logic signed [EXT_W-1:0] c;
    logic signed [EXT_W-1:0] v;
    g = signed'(EXT_W'(rsum)) - signed'(EXT_W'(lsum));
    c = signed'(EXT_W'(cap));
    if (g < -c) begin
      v = '0;
    end else if (g > c) begin
      v = g + g;
    end else begin
      v = g + c;
    end
    if (v < 0) begin
      v = '0;
    end
    if (v > signed'(EXT_W'(VALUE_MAX))) begin
      v = signed'(EXT_W'(VALUE_MAX));
    end
    return v[VAL_W-1:0];
  endfunction

endpackage

// File: rtl/stereo_sobel_x_cap_filter_core.sv
// channel   | dir | handshake                  | payload
// ----------+-----+----------------------------+-------------------------------------------
// s_axis    | in  | s_axis_tvalid_i / _tready_o | tdata: left_pixel, right_pixel; tuser: frame_start
// m_axis    | out | m_axis_tvalid_o / _tready_i | tdata: out_row, out_col, left_value, right_value;
//           |     |                            | tlast: last_of_run
// cfg       | in  | cfg_valid_i / cfg_ready_o   | cfg_addr_i: register index, cfg_data_i: value
//
// line store read and write happen at the edge that accepts a pixel pair; once the output
// slots drain, it is folded into the 3x3 windows and up to three result words go into the
// slots. sustained rate is one pixel per cycle wherever a pixel causes at most one result
// and no word stalls; on the last row of a frame a pixel causes up to three, so the single
// output port holds the input back. reset clears counters, windows and registers at once
// (no clearing pass: the line stores hold whatever was there until written). a stalled
// output keeps one more pixel waiting in the input register before s_axis_tready_o drops.
module stereo_sobel_x_cap_filter_core
  import ssxcf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [15:0]           s_axis_tdata_i,   // left_pixel[7:0], right_pixel[15:8]
  input  logic                  s_axis_tuser_i,   // frame_start

  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [47:0]           m_axis_tdata_o,   // out_row[11:0], out_col[21:12],
                                                  // left_value[32:22], right_value[43:33],
                                                  // zero[47:44]
  output logic                  m_axis_tlast_o,   // last_of_run

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  logic [CAP_W-1:0]    cap_q;
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= CAP_RESET;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_GRADIENT_CAP: cap_q    <= cfg_data_i[CAP_W-1:0];
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size, clamped to the supported range
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;

  always_comb begin
    if (width_q < WIDTH_W'(3)) begin
      w_eff = WIDTH_W'(3);
    end else if (width_q > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q < HEIGHT_W'(3)) begin
      h_eff = HEIGHT_W'(3);
    end else if (height_q > HEIGHT_W'(MAX_HEIGHT)) begin
      h_eff = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  // ------------------------------------------------------------------
  // input side: position counters and per-pixel flags
  // ------------------------------------------------------------------
  logic                  in_acc;
  logic                  b_load;
  logic [PIXEL_BITS-1:0] lp, rp;
  logic                  fs;
  logic [ROW_W-1:0]      row_q, row_d, r_use;
  logic [COL_W-1:0]      col_q, col_d, c_use;
  logic [HEIGHT_W-1:0]   r_ext, h_last;
  logic [WIDTH_W-1:0]    c_ext, w_last;
  logic                  c_in, f_int, f_edge;

  assign lp = s_axis_tdata_i[PIXEL_BITS-1:0];
  assign rp = s_axis_tdata_i[2*PIXEL_BITS-1:PIXEL_BITS];
  assign fs = s_axis_tuser_i;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  assign r_use  = fs ? '0 : row_q;
  assign c_use  = fs ? '0 : col_q;
  assign r_ext  = HEIGHT_W'(r_use);
  assign c_ext  = WIDTH_W'(c_use);
  assign h_last = h_eff - HEIGHT_W'(1);
  assign w_last = w_eff - WIDTH_W'(1);

  assign c_in   = c_ext < w_eff;
  assign f_int  = (r_ext >= HEIGHT_W'(2)) && (r_ext <= h_last) && c_in;
  assign f_edge = ((r_use == '0) || (r_ext == h_last)) && c_in;

  // wrap the column at the last one, then the row
  always_comb begin
    if (c_ext + WIDTH_W'(1) >= w_eff) begin
      col_d = '0;
      if (r_ext + HEIGHT_W'(1) >= h_eff) begin
        row_d = '0;
      end else begin
        row_d = r_use + ROW_W'(1);
      end
    end else begin
      col_d = c_use + COL_W'(1);
      row_d = r_use;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_acc) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // ------------------------------------------------------------------
  // line stores: one bank per row parity, read-first at the accept edge
  // ------------------------------------------------------------------
  logic [PIXEL_BITS-1:0] l_bank0 [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] l_bank1 [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] r_bank0 [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] r_bank1 [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] l_rd0_q, l_rd1_q, r_rd0_q, r_rd1_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      l_rd0_q <= l_bank0[c_use];
      l_rd1_q <= l_bank1[c_use];
      if (r_use[0]) begin
        l_bank1[c_use] <= lp;
      end else begin
        l_bank0[c_use] <= lp;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      r_rd0_q <= r_bank0[c_use];
      r_rd1_q <= r_bank1[c_use];
      if (r_use[0]) begin
        r_bank1[c_use] <= rp;
      end else begin
        r_bank0[c_use] <= rp;
      end
    end
  end

  // ------------------------------------------------------------------
  // input register
  // ------------------------------------------------------------------
  logic                  a_valid_q;
  logic [PIXEL_BITS-1:0] a_lp_q, a_rp_q;
  logic [ROW_W-1:0]      a_row_q;
  logic [COL_W-1:0]      a_col_q;
  logic                  a_int_q, a_c0_q, a_grad_q, a_clast_q, a_edge_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_acc) begin
      a_valid_q <= 1'b1;
    end else if (b_load) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_lp_q    <= lp;
      a_rp_q    <= rp;
      a_row_q   <= r_use;
      a_col_q   <= c_use;
      a_int_q   <= f_int;
      a_c0_q    <= (c_use == '0);
      a_grad_q  <= (c_use >= COL_W'(2));
      a_clast_q <= (c_ext == w_last);
      a_edge_q  <= f_edge;
    end
  end

  assign s_axis_tready_o = !a_valid_q || b_load;

  // ------------------------------------------------------------------
  // windows: only the two older columns are kept, the new one comes
  // straight from the line store read and the input pixel
  // ------------------------------------------------------------------
  logic [PIXEL_BITS-1:0] l_win1_q [3];
  logic [PIXEL_BITS-1:0] l_win2_q [3];
  logic [PIXEL_BITS-1:0] r_win1_q [3];
  logic [PIXEL_BITS-1:0] r_win2_q [3];
  logic [PIXEL_BITS-1:0] l_new [3];
  logic [PIXEL_BITS-1:0] r_new [3];

  // top row is r-2 (same parity bank), middle row r-1
  assign l_new[0] = a_row_q[0] ? l_rd1_q : l_rd0_q;
  assign l_new[1] = a_row_q[0] ? l_rd0_q : l_rd1_q;
  assign l_new[2] = a_lp_q;
  assign r_new[0] = a_row_q[0] ? r_rd1_q : r_rd0_q;
  assign r_new[1] = a_row_q[0] ? r_rd0_q : r_rd1_q;
  assign r_new[2] = a_rp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        l_win1_q[i] <= '0;
        l_win2_q[i] <= '0;
        r_win1_q[i] <= '0;
        r_win2_q[i] <= '0;
      end
    end else if (b_load) begin
      for (int i = 0; i < 3; i++) begin
        l_win1_q[i] <= l_win2_q[i];
        l_win2_q[i] <= l_new[i];
        r_win1_q[i] <= r_win2_q[i];
        r_win2_q[i] <= r_new[i];
      end
    end
  end

  // gradient: newest column minus the one two steps back
  logic [VAL_W-1:0] l_grad, r_grad;

  assign l_grad = map_gradient(column_sum(l_new[0], l_new[1], l_new[2]),
                               column_sum(l_win1_q[0], l_win1_q[1], l_win1_q[2]), cap_q);
  assign r_grad = map_gradient(column_sum(r_new[0], r_new[1], r_new[2]),
                               column_sum(r_win1_q[0], r_win1_q[1], r_win1_q[2]), cap_q);

  // ------------------------------------------------------------------
  // gather up to three result words in output order
  // ------------------------------------------------------------------
  result_t          slot_new [SLOTS];
  logic [CNT_W-1:0] new_n;
  result_t          r_copy_mid, r_gradw, r_copy_cur;
  logic [ROW_W-1:0] row_up;

  assign row_up = a_row_q - ROW_W'(1);

  always_comb begin
    r_copy_mid.out_row     = row_up;
    r_copy_mid.out_col     = a_col_q;
    r_copy_mid.left_value  = VAL_W'(l_new[1]);
    r_copy_mid.right_value = VAL_W'(r_new[1]);

    r_gradw.out_row        = row_up;
    r_gradw.out_col        = a_col_q - COL_W'(1);
    r_gradw.left_value     = l_grad;
    r_gradw.right_value    = r_grad;

    r_copy_cur.out_row     = a_row_q;
    r_copy_cur.out_col     = a_col_q;
    r_copy_cur.left_value  = VAL_W'(a_lp_q);
    r_copy_cur.right_value = VAL_W'(a_rp_q);
  end

  always_comb begin
    new_n = '0;
    for (int k = 0; k < SLOTS; k++) begin
      slot_new[k] = '0;
    end
    // first column of an interior row: copy of its left border
    if (a_int_q && a_c0_q) begin
      slot_new[new_n] = r_copy_mid;
      new_n = new_n + CNT_W'(1);
    end
    if (a_int_q && a_grad_q) begin
      slot_new[new_n] = r_gradw;
      new_n = new_n + CNT_W'(1);
    end
    // last column of an interior row: copy of its right border
    if (a_int_q && a_clast_q) begin
      slot_new[new_n] = r_copy_mid;
      new_n = new_n + CNT_W'(1);
    end
    // top and bottom rows pass straight through
    if (a_edge_q) begin
      slot_new[new_n] = r_copy_cur;
      new_n = new_n + CNT_W'(1);
    end
  end

  // ------------------------------------------------------------------
  // output slots: slot 0 drives the port, pops shift the rest down
  // ------------------------------------------------------------------
  result_t          slot_q [SLOTS];
  logic [CNT_W-1:0] cnt_q;
  logic             pop;

  assign pop    = m_axis_tvalid_o && m_axis_tready_i;
  assign b_load = a_valid_q && ((cnt_q == '0) || ((cnt_q == CNT_W'(1)) && pop));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (b_load) begin
      cnt_q <= new_n;
    end else if (pop) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_load) begin
      for (int k = 0; k < SLOTS; k++) begin
        slot_q[k] <= slot_new[k];
      end
    end else if (pop) begin
      for (int k = 0; k < SLOTS - 1; k++) begin
        slot_q[k] <= slot_q[k+1];
      end
    end
  end

  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = {4'b0000, slot_q[0]};
  assign m_axis_tlast_o  = (cnt_q == CNT_W'(1));

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(SLOTS))
    else $error("output slot count out of range");

  a_hold_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !b_load) |=> a_valid_q)
    else $error("pending pixel dropped before loading");

  a_frame_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && fs) |=> (a_row_q == '0) && (a_col_q == '0))
    else $error("frame start did not reset position");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !b_load) |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("slot count not decremented on pop");

  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_load && !pop) |-> (cnt_q == '0))
    else $error("results loaded over pending words");

endmodule

// File: bench/tb_stereo_sobel_x_cap_filter_core.sv
`timescale 1ns / 1ps

module tb_stereo_sobel_x_cap_filter_core;
  import ssxcf_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  // covers the input register, the window stage and the output slots
  localparam int DRAIN_CYCLES = 12;
  localparam int PIX_TOP      = 8 * 255;

  typedef enum logic [1:0] {
    STEP_PIXEL,
    STEP_CFG
  } step_kind_e;

  // one row of the directed table; the e_* fields hold a typed-in expectation
  typedef struct {
    step_kind_e kind;
    cfg_idx_e   reg_idx;
    int         reg_val;
    logic [7:0] lpix;
    logic [7:0] rpix;
    logic       fs;
    bit         typed;
    int         e_row;
    int         e_col;
    int         e_lv;
    int         e_rv;
  } stim_row_t;

  typedef struct {
    result_t word;
    logic    last;
  } exp_word_t;

  typedef logic [7:0] pix_win_t [3][3];

  // dut side signals, the inputs known from time zero
  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  s_tvalid   = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata    = '0;   // left_pixel[7:0], right_pixel[15:8]
  logic                  s_tuser    = 1'b0; // frame_start
  logic                  m_tvalid;
  logic                  m_tready   = 1'b0;
  logic [47:0]           m_tdata;           // out_row, out_col, left_value, right_value
  logic                  m_tlast;           // last_of_run
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // predictor state: registers, line rows, windows and raster position
  logic [CAP_W-1:0]    cap_q;
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [7:0]          left_rows  [2*MAX_WIDTH];
  logic [7:0]          right_rows [2*MAX_WIDTH];
  pix_win_t            left_win;
  pix_win_t            right_win;
  int                  row_q;
  int                  col_q;

  exp_word_t   expected_words [$];
  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int          send_gap_pct   = 0;
  int          recv_stall_pct = 0;
  int          random_items   = 0;

  // directed rows: extremes, frame_start mid row, cap of zero, out of range sizes,
  // unused register index; typed expectations only for plain pixel copies
  stim_row_t directed_steps [35] = '{
    // defaults after reset: row 0 copies
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'h00, 8'hFF, 1'b1, 1'b1, 0, 0, 0, 255},
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'hFF, 8'h00, 1'b0, 1'b1, 0, 1, 255, 0},
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'hAA, 8'h55, 1'b0, 1'b1, 0, 2, 170, 85},
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'h55, 8'hAA, 1'b1, 1'b1, 0, 0, 85, 170},
    // top cap, smallest frame
    '{STEP_CFG, CFG_GRADIENT_CAP, 1020, 8'h00, 8'h00, 1'b0, 1'b0, 0, 0, 0, 0},
    '{STEP_CFG, CFG_IMAGE_WIDTH,  3,    8'h00, 8'h00, 1'b0, 1'b0, 0, 0, 0, 0},
    '{STEP_CFG, CFG_IMAGE_HEIGHT, 3,    8'h00, 8'h00, 1'b0, 1'b0, 0, 0, 0, 0},
    '{STEP_CFG, CFG_UNUSED,       8191, 8'h00, 8'h00, 1'b0, 1'b0, 0, 0, 0, 0},
    // steepest edges: left saturates high, right lands exactly on minus cap
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'h00, 8'hFF, 1'b1, 1'b1, 0, 0, 0, 255},
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'h00, 8'hFF, 1'b0, 1'b1, 0, 1, 0, 255},
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'hFF, 8'h00, 1'b0, 1'b1, 0, 2, 255, 0},
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'h00, 8'hFF, 1'b0, 1'b0, 0, 0, 0, 0},
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'h00, 8'hFF, 1'b0, 1'b0, 0, 0, 0, 0},
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'hFF, 8'h00, 1'b0, 1'b0, 0, 0, 0, 0},
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'h00, 8'hFF, 1'b0, 1'b0, 0, 0, 0, 0},
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'h00, 8'hFF, 1'b0, 1'b0, 0, 0, 0, 0},
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'hFF, 8'h00, 1'b0, 1'b0, 0, 0, 0, 0},
    // cap of zero, sizes below range
    '{STEP_CFG, CFG_GRADIENT_CAP, 0, 8'h00, 8'h00, 1'b0, 1'b0, 0, 0, 0, 0},
    '{STEP_CFG, CFG_IMAGE_WIDTH,  2, 8'h00, 8'h00, 1'b0, 1'b0, 0, 0, 0, 0},
    '{STEP_CFG, CFG_IMAGE_HEIGHT, 1, 8'h00, 8'h00, 1'b0, 1'b0, 0, 0, 0, 0},
    // flat left image gives zero gradient, right rises by one
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'd100, 8'd0, 1'b1, 1'b1, 0, 0, 100, 0},
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'd100, 8'd0, 1'b0, 1'b1, 0, 1, 100, 0},
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'd100, 8'd1, 1'b0, 1'b1, 0, 2, 100, 1},
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'd100, 8'd0, 1'b0, 1'b0, 0, 0, 0, 0},
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'd100, 8'd0, 1'b0, 1'b0, 0, 0, 0, 0},
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'd100, 8'd1, 1'b0, 1'b0, 0, 0, 0, 0},
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'd100, 8'd0, 1'b0, 1'b0, 0, 0, 0, 0},
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'd100, 8'd0, 1'b0, 1'b0, 0, 0, 0, 0},
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'd100, 8'd1, 1'b0, 1'b0, 0, 0, 0, 0},
    // cap of one, all-ones raw sizes above range
    '{STEP_CFG, CFG_GRADIENT_CAP, 1,    8'h00, 8'h00, 1'b0, 1'b0, 0, 0, 0, 0},
    '{STEP_CFG, CFG_IMAGE_WIDTH,  2047, 8'h00, 8'h00, 1'b0, 1'b0, 0, 0, 0, 0},
    '{STEP_CFG, CFG_IMAGE_HEIGHT, 8191, 8'h00, 8'h00, 1'b0, 1'b0, 0, 0, 0, 0},
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'hFF, 8'hFF, 1'b1, 1'b1, 0, 0, 255, 255},
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'h00, 8'h00, 1'b0, 1'b1, 0, 1, 0, 0},
    '{STEP_PIXEL, CFG_UNUSED, 0, 8'h01, 8'h80, 1'b0, 1'b1, 0, 2, 1, 128}
  };

  stereo_sobel_x_cap_filter_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  // sizes in use after clamping
  function automatic int eff_width();
    if (width_q < 3) return 3;
    if (width_q > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_q);
  endfunction

  function automatic int eff_height();
    if (height_q < 3) return 3;
    if (height_q > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(height_q);
  endfunction

  // horizontal sobel, then zero / doubled / offset mapping against the cap, clamped to PIX_TOP
  function automatic logic [VAL_W-1:0] cap_gradient(pix_win_t w);
    int g;
    int c;
    int v;
    g = (int'(w[0][2]) + 2 * int'(w[1][2]) + int'(w[2][2]))
      - (int'(w[0][0]) + 2 * int'(w[1][0]) + int'(w[2][0]));
    c = int'(cap_q);
    if (g < -c) v = 0;
    else if (g > c) v = 2 * g;
    else v = g + c;
    if (v < 0) v = 0;
    if (v > PIX_TOP) v = PIX_TOP;
    return VAL_W'(v);
  endfunction

  function automatic void push_word(int r, int c, int lv, int rv);
    exp_word_t e;
    e.word.out_row     = ROW_W'(r);
    e.word.out_col     = COL_W'(c);
    e.word.left_value  = VAL_W'(lv);
    e.word.right_value = VAL_W'(rv);
    e.last             = 1'b0;
    expected_words.push_back(e);
  endfunction

  function automatic void reset_model();
    cap_q    = CAP_RESET;
    width_q  = WIDTH_RESET;
    height_q = HEIGHT_RESET;
    for (int i = 0; i < 2 * MAX_WIDTH; i++) begin
      left_rows[i]  = '0;
      right_rows[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        left_win[i][j]  = '0;
        right_win[i][j] = '0;
      end
    end
    row_q = 0;
    col_q = 0;
  endfunction

  // one accepted pixel pair: window shift, line row update, result words, advance
  function automatic void predict_pixel(logic [7:0] lp, logic [7:0] rp, logic fs,
                                        output int n);
    int w;
    int h;
    int r;
    int c;
    int cur;
    int prv;
    int base;
    w = eff_width();
    h = eff_height();
    if (fs) begin
      row_q = 0;
      col_q = 0;
    end
    r    = row_q;
    c    = col_q;
    cur  = (r % 2) * MAX_WIDTH + c;
    prv  = ((r + 1) % 2) * MAX_WIDTH + c;
    base = expected_words.size();
    for (int i = 0; i < 3; i++) begin
      left_win[i][0]  = left_win[i][1];
      left_win[i][1]  = left_win[i][2];
      right_win[i][0] = right_win[i][1];
      right_win[i][1] = right_win[i][2];
    end
    // new column: rows r-2, r-1 from the line store, row r from the input
    left_win[0][2]  = left_rows[cur];
    left_win[1][2]  = left_rows[prv];
    left_win[2][2]  = lp;
    right_win[0][2] = right_rows[cur];
    right_win[1][2] = right_rows[prv];
    right_win[2][2] = rp;
    left_rows[cur]  = lp;
    right_rows[cur] = rp;
    // interior row r-1 finishes as row r streams in
    if (r >= 2 && r <= h - 1 && c < w) begin
      if (c == 0) push_word(r - 1, 0, left_win[1][2], right_win[1][2]);
      if (c >= 2) push_word(r - 1, c - 1, cap_gradient(left_win), cap_gradient(right_win));
      if (c == w - 1) push_word(r - 1, c, left_win[1][2], right_win[1][2]);
    end
    // first and last rows pass straight through
    if ((r == 0 || r == h - 1) && c < w) push_word(r, c, lp, rp);
    n = expected_words.size() - base;
    if (n > 0) expected_words[expected_words.size() - 1].last = 1'b1;
    // column wraps at or beyond the width, row likewise at the height
    if (c + 1 >= w) begin
      col_q = 0;
      row_q = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_q = c + 1;
    end
  endfunction

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // hold off input until every expected word is out and the pipe is empty
  task automatic drain_block();
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, int val);
    drain_block();
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_GRADIENT_CAP: cap_q    = CAP_W'(val);
      CFG_IMAGE_WIDTH:  width_q  = WIDTH_W'(val);
      CFG_IMAGE_HEIGHT: height_q = HEIGHT_W'(val);
      default: ;
    endcase
  endtask

  // random gap before the word, then hold it until taken
  task automatic send_pixel(logic [7:0] lp, logic [7:0] rp, logic fs, output int n);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rp, lp};
    s_tuser  <= fs;
    do @(posedge clk_i); while (!s_tready);
    predict_pixel(lp, rp, fs, n);
  endtask

  // one small frame under fresh settings; sometimes broken by a stray frame_start,
  // sometimes resized mid frame (width only shrinks so line rows stay written)
  task automatic run_segment();
    int   cap_raw;
    int   w_raw;
    int   h_raw;
    int   total;
    int   split;
    int   n;
    bit   mid_change;
    logic fs;
    case ($urandom_range(0, 5))
      0:       cap_raw = 0;
      1:       cap_raw = 1;
      2:       cap_raw = 1020;
      3:       cap_raw = 1023;
      4:       cap_raw = $urandom_range(0, 8191);
      default: cap_raw = $urandom_range(2, 120);
    endcase
    w_raw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
    case ($urandom_range(0, 7))
      0:       h_raw = $urandom_range(0, 2);
      1:       h_raw = $urandom_range(4097, 8191);
      default: h_raw = $urandom_range(3, 6);
    endcase
    cfg_write(CFG_GRADIENT_CAP, cap_raw);
    cfg_write(CFG_IMAGE_WIDTH, w_raw);
    cfg_write(CFG_IMAGE_HEIGHT, h_raw);
    // tall frames are cut after a few rows
    if (eff_height() > 8) total = 3 * eff_width() + $urandom_range(0, eff_width());
    else total = eff_width() * eff_height();
    mid_change = ($urandom_range(0, 3) == 0);
    split      = $urandom_range(1, total - 1);
    for (int k = 0; k < total; k++) begin
      if (mid_change && k == split) begin
        cfg_write(CFG_IMAGE_WIDTH, $urandom_range(0, eff_width()));
        cfg_write(CFG_IMAGE_HEIGHT, $urandom_range(0, 8));
      end
      fs = (k == 0) || ($urandom_range(0, 39) == 0);
      send_pixel(pick_pixel(), pick_pixel(), fs, n);
      random_items++;
    end
  endtask

  // output side: compare each taken word with the oldest expectation, then
  // pick the next ready
  always @(posedge clk_i) begin : out_check
    exp_word_t e;
    result_t   got;
    if (rst_ni && m_tvalid && m_tready) begin
      got = m_tdata[$bits(result_t)-1:0];
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected word: row %0d col %0d left %0d right %0d last %0b",
                   got.out_row, got.out_col, got.left_value, got.right_value, m_tlast);
        end
      end else begin
        e = expected_words.pop_front();
        if (got.out_row !== e.word.out_row || got.out_col !== e.word.out_col ||
            got.left_value !== e.word.left_value ||
            got.right_value !== e.word.right_value || m_tlast !== e.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected row %0d col %0d left %0d right %0d last %0b",
                     e.word.out_row, e.word.out_col, e.word.left_value,
                     e.word.right_value, e.last);
            $display("          got      row %0d col %0d left %0d right %0d last %0b",
                     got.out_row, got.out_col, got.left_value, got.right_value, m_tlast);
          end
        end
      end
    end
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_stereo_sobel_x_cap_filter_core NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int        n;
    int        first_items;
    stim_row_t row;
    reset_model();
    send_gap_pct   = 7;
    recv_stall_pct = 58;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < $size(directed_steps); i++) begin
      row = directed_steps[i];
      if (row.kind == STEP_CFG) begin
        cfg_write(row.reg_idx, row.reg_val);
      end else begin
        send_pixel(row.lpix, row.rpix, row.fs, n);
        if (row.typed) begin
          repeat (n) void'(expected_words.pop_back());
          push_word(row.e_row, row.e_col, row.e_lv, row.e_rv);
          expected_words[expected_words.size() - 1].last = 1'b1;
        end
      end
    end

    // random frames: slow receiver, slow sender, then full speed
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct   = 7;
          recv_stall_pct = 58;
        end
        1: begin
          send_gap_pct   = 58;
          recv_stall_pct = 7;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      first_items = random_items;
      while (random_items - first_items < 30) run_segment();
    end

    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_stereo_sobel_x_cap_filter_core OK");
    end else begin
      $display("tb_stereo_sobel_x_cap_filter_core NOT OK");
    end
    $finish;
  end

endmodule
